// ----- src/belt_block_cipher_unit_macros.svh -----
// Assertion macros shared by the belt cipher unit.
`ifndef BELT_BLOCK_CIPHER_UNIT_MACROS_SVH
`define BELT_BLOCK_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BELT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BELT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/belt_pkg.sv -----
// Types, constants and the byte substitution shared by the belt cipher unit.
package belt_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KEY_01   = 3'd0;
  localparam logic [2:0] CFG_KEY_23   = 3'd1;
  localparam logic [2:0] CFG_KEY_45   = 3'd2;
  localparam logic [2:0] CFG_KEY_67   = 3'd3;
  localparam logic [2:0] CFG_KEY_SIZE = 3'd4;

  // Key size codes; any other code selects the full 256-bit key.
  localparam logic [1:0] KEY_SIZE_128 = 2'd0;
  localparam logic [1:0] KEY_SIZE_192 = 2'd1;
  localparam logic [1:0] KEY_SIZE_256 = 2'd2;

  // Command codes carried in the cmd field of an input transaction.
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam int unsigned ROUNDS = 8;
  localparam int unsigned STEPS  = 7;
  localparam int unsigned STAGES = ROUNDS * STEPS;

  typedef struct packed {
    logic        cmd;
    logic [31:0] in_word0;
    logic [31:0] in_word1;
    logic [31:0] in_word2;
    logic [31:0] in_word3;
  } belt_in_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
  } belt_out_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } belt_state_t;

  typedef logic [7:0][31:0] belt_key_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hB1, 8'h94, 8'hBA, 8'hC8, 8'h0A, 8'h08, 8'hF5, 8'h3B,
    8'h36, 8'h6D, 8'h00, 8'h8E, 8'h58, 8'h4A, 8'h5D, 8'hE4,
    8'h85, 8'h04, 8'hFA, 8'h9D, 8'h1B, 8'hB6, 8'hC7, 8'hAC,
    8'h25, 8'h2E, 8'h72, 8'hC2, 8'h02, 8'hFD, 8'hCE, 8'h0D,
    8'h5B, 8'hE3, 8'hD6, 8'h12, 8'h17, 8'hB9, 8'h61, 8'h81,
    8'hFE, 8'h67, 8'h86, 8'hAD, 8'h71, 8'h6B, 8'h89, 8'h0B,
    8'h5C, 8'hB0, 8'hC0, 8'hFF, 8'h33, 8'hC3, 8'h56, 8'hB8,
    8'h35, 8'hC4, 8'h05, 8'hAE, 8'hD8, 8'hE0, 8'h7F, 8'h99,
    8'hE1, 8'h2B, 8'hDC, 8'h1A, 8'hE2, 8'h82, 8'h57, 8'hEC,
    8'h70, 8'h3F, 8'hCC, 8'hF0, 8'h95, 8'hEE, 8'h8D, 8'hF1,
    8'hC1, 8'hAB, 8'h76, 8'h38, 8'h9F, 8'hE6, 8'h78, 8'hCA,
    8'hF7, 8'hC6, 8'hF8, 8'h60, 8'hD5, 8'hBB, 8'h9C, 8'h4F,
    8'hF3, 8'h3C, 8'h65, 8'h7B, 8'h63, 8'h7C, 8'h30, 8'h6A,
    8'hDD, 8'h4E, 8'hA7, 8'h79, 8'h9E, 8'hB2, 8'h3D, 8'h31,
    8'h3E, 8'h98, 8'hB5, 8'h6E, 8'h27, 8'hD3, 8'hBC, 8'hCF,
    8'h59, 8'h1E, 8'h18, 8'h1F, 8'h4C, 8'h5A, 8'hB7, 8'h93,
    8'hE9, 8'hDE, 8'hE7, 8'h2C, 8'h8F, 8'h0C, 8'h0F, 8'hA6,
    8'h2D, 8'hDB, 8'h49, 8'hF4, 8'h6F, 8'h73, 8'h96, 8'h47,
    8'h06, 8'h07, 8'h53, 8'h16, 8'hED, 8'h24, 8'h7A, 8'h37,
    8'h39, 8'hCB, 8'hA3, 8'h83, 8'h03, 8'hA9, 8'h8B, 8'hF6,
    8'h92, 8'hBD, 8'h9B, 8'h1C, 8'hE5, 8'hD1, 8'h41, 8'h01,
    8'h54, 8'h45, 8'hFB, 8'hC9, 8'h5E, 8'h4D, 8'h0E, 8'hF2,
    8'h68, 8'h20, 8'h80, 8'hAA, 8'h22, 8'h7D, 8'h64, 8'h2F,
    8'h26, 8'h87, 8'hF9, 8'h34, 8'h90, 8'h40, 8'h55, 8'h11,
    8'hBE, 8'h32, 8'h97, 8'h13, 8'h43, 8'hFC, 8'h9A, 8'h48,
    8'hA0, 8'h2A, 8'h88, 8'h5F, 8'h19, 8'h4B, 8'h09, 8'hA1,
    8'h7E, 8'hCD, 8'hA4, 8'hD0, 8'h15, 8'h44, 8'hAF, 8'h8C,
    8'hA5, 8'h84, 8'h50, 8'hBF, 8'h66, 8'hD2, 8'hE8, 8'h8A,
    8'hA2, 8'hD7, 8'h46, 8'h52, 8'h42, 8'hA8, 8'hDF, 8'hB3,
    8'h69, 8'h74, 8'hC5, 8'h51, 8'hEB, 8'h23, 8'h29, 8'h21,
    8'hD4, 8'hEF, 8'hD9, 8'hB4, 8'h3A, 8'h62, 8'h28, 8'h75,
    8'h91, 8'h14, 8'h10, 8'hEA, 8'h77, 8'h6C, 8'hDA, 8'h1D
  };

  // Substitutes every byte of a word through the S-box.
  function automatic logic [31:0] belt_sub(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

endpackage

// ----- src/belt_block_cipher_unit.sv -----
// Top level of the belt block cipher unit: key registers, round pipeline and output stage.
//
// The unit encrypts or decrypts one 128-bit block per transaction and accepts a new
// transaction in every cycle while in_stall_o is low. A block passes through a chain of
// 56 cells, one for each G step of the eight rounds (seven steps a round), and results
// leave at one per cycle, in order, while the result channel does not stall. The chain
// moves as a whole; it halts only when the result channel has stalled long enough to fill
// both the output register and its skid entry, and in_stall_o is then raised from that
// registered state. The key is held in four 64-bit registers plus a key-size register; the
// expanded key is formed from them combinationally and read by every cell, so registers
// may only be written while no transaction is in flight. Key size 0 repeats words 0 to 3,
// size 1 derives words 6 and 7 by XOR, and sizes 2 and 3 use all eight words. Writes to
// register indexes beyond the key-size register are ignored.

`include "belt_block_cipher_unit_macros.svh"

module belt_block_cipher_unit
  import belt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  belt_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output belt_out_t   out_data_o
);

  logic [63:0] key01_q;
  logic [63:0] key23_q;
  logic [63:0] key45_q;
  logic [63:0] key67_q;
  logic [1:0]  key_size_q;
  belt_key_t   key;

  logic              pipe_en;
  logic              skid_full;
  logic              out_push;
  logic [STAGES:0]   pipe_valid;
  belt_state_t       pipe_st [STAGES+1];
  belt_state_t       last_st;
  belt_out_t         result;

  // Configuration writes; unknown indexes fall through untouched.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q    <= '0;
      key23_q    <= '0;
      key45_q    <= '0;
      key67_q    <= '0;
      key_size_q <= KEY_SIZE_256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_01:   key01_q    <= cfg_wdata_i;
        CFG_KEY_23:   key23_q    <= cfg_wdata_i;
        CFG_KEY_45:   key45_q    <= cfg_wdata_i;
        CFG_KEY_67:   key67_q    <= cfg_wdata_i;
        CFG_KEY_SIZE: key_size_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Key expansion into eight 32-bit words.
  always_comb begin
    key[0] = key01_q[31:0];
    key[1] = key01_q[63:32];
    key[2] = key23_q[31:0];
    key[3] = key23_q[63:32];
    key[4] = key45_q[31:0];
    key[5] = key45_q[63:32];
    key[6] = key67_q[31:0];
    key[7] = key67_q[63:32];
    priority if (key_size_q == KEY_SIZE_128) begin
      key[4] = key01_q[31:0];
      key[5] = key01_q[63:32];
      key[6] = key23_q[31:0];
      key[7] = key23_q[63:32];
    end else if (key_size_q == KEY_SIZE_192) begin
      key[6] = key01_q[31:0] ^ key01_q[63:32] ^ key23_q[31:0];
      key[7] = key23_q[63:32] ^ key45_q[31:0] ^ key45_q[63:32];
    end else begin
    end
  end

  // The chain advances whenever the output stage has room for one more result.
  assign pipe_en    = !skid_full;
  assign in_stall_o = skid_full;

  assign pipe_valid[0] = in_valid_i;
  assign pipe_st[0]    = '{cmd: in_data_i.cmd,
                           a:   in_data_i.in_word0,
                           b:   in_data_i.in_word1,
                           c:   in_data_i.in_word2,
                           d:   in_data_i.in_word3};

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    belt_step_cell #(
      .ROUND_IDX(i / STEPS),
      .STEP     (i % STEPS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .valid_i(pipe_valid[i]),
      .st_i   (pipe_st[i]),
      .key_i  (key),
      .valid_o(pipe_valid[i+1]),
      .st_o   (pipe_st[i+1])
    );
  end

  // The final word order differs between the two directions.
  assign last_st = pipe_st[STAGES];
  always_comb begin
    if (last_st.cmd == CMD_DECRYPT) begin
      result = '{out_word0: last_st.c, out_word1: last_st.a,
                 out_word2: last_st.d, out_word3: last_st.b};
    end else begin
      result = '{out_word0: last_st.b, out_word1: last_st.d,
                 out_word2: last_st.a, out_word3: last_st.c};
    end
  end

  assign out_push = pipe_en && pipe_valid[STAGES];

  belt_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (out_push),
    .data_i     (result),
    .full_o     (skid_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // A result can sit in the skid entry only behind one in the output register.
  `BELT_ASSERT_NOW(a_skid_behind_out, skid_full, out_valid_o, "skid entry full without output")
  // A result pushed while the output is stalled must land in the skid entry.
  `BELT_ASSERT_NEXT(a_stall_push, out_valid_o && out_stall_i && out_push, skid_full, "push lost")
  // While the chain is halted no transaction moves between cells.
  `BELT_ASSERT_NEXT(a_chain_frozen, !pipe_en, $stable(pipe_valid[STAGES:1]), "chain moved")

endmodule

// ----- src/belt_step_cell.sv -----
// One G step of a belt round, registered: one cell of the cipher pipeline.
module belt_step_cell
  import belt_pkg::*;
#(
  parameter int unsigned ROUND_IDX = 0,
  parameter int unsigned STEP      = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  belt_state_t st_i,
  input  belt_key_t   key_i,
  output logic        valid_o,
  output belt_state_t st_o
);

  // Key word positions for encryption and for decryption, which runs rounds backwards.
  localparam logic [2:0] KEY_ENC = 3'((7 * ROUND_IDX + STEP) % 8);
  localparam logic [2:0] KEY_DEC = 3'((7 * (ROUNDS - 1 - ROUND_IDX) + (STEPS - 1 - STEP)) % 8);
  localparam logic [31:0] RC_ENC = 32'(ROUND_IDX + 1);
  localparam logic [31:0] RC_DEC = 32'(ROUNDS - ROUND_IDX);
  localparam int unsigned ROT = (STEP == 0 || STEP == 6) ? 5 :
                                (STEP == 2 || STEP == 4) ? 13 : 21;

  logic        valid_q;
  belt_state_t st_q;
  belt_state_t st_d;
  logic [31:0] kw;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] g;
  logic [31:0] e;
  logic [31:0] c_mix;

  always_comb begin
    kw = (st_i.cmd == CMD_DECRYPT) ? key_i[KEY_DEC] : key_i[KEY_ENC];
    unique case (STEP)
      0, 5:    x = st_i.a + kw;
      1, 6:    x = st_i.d + kw;
      2:       x = st_i.b + kw;
      3:       x = st_i.b + st_i.c + kw;
      default: x = st_i.c + kw;
    endcase
    y = belt_sub(x);
    g = (y << ROT) | (y >> (32 - ROT));
    e = g ^ ((st_i.cmd == CMD_DECRYPT) ? RC_DEC : RC_ENC);
    c_mix = st_i.c ^ g;
    st_d = st_i;
    unique case (STEP)
      0, 5: st_d.b = st_i.b ^ g;
      1:    st_d.c = c_mix;
      2:    st_d.a = st_i.a - g;
      3: begin
        st_d.b = st_i.b + e;
        st_d.c = st_i.c - e;
      end
      4:    st_d.d = st_i.d + g;
      default: begin
        // Last step of the round mixes c, then the words change places.
        if (st_i.cmd == CMD_DECRYPT) begin
          st_d.a = c_mix;
          st_d.b = st_i.a;
          st_d.c = st_i.d;
          st_d.d = st_i.b;
        end else begin
          st_d.a = st_i.b;
          st_d.b = st_i.d;
          st_d.c = st_i.a;
          st_d.d = c_mix;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

// ----- src/belt_out_skid.sv -----
// Output register with a skid entry for the result channel.
module belt_out_skid
  import belt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  belt_out_t data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output belt_out_t out_data_o
);

  logic      out_valid_q;
  logic      skid_valid_q;
  belt_out_t out_q;
  belt_out_t skid_q;
  logic      hold;

  // The output holds while a valid result is stalled; otherwise it refills.
  assign hold = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (hold) begin
      if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold) begin
      if (push_i) begin
        skid_q <= data_i;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (push_i) begin
      out_q <= data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the belt block cipher unit, with its own cipher predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import belt_pkg::*;

  // Time for a result to leave the round chain after its transaction is accepted.
  localparam int unsigned LATENCY     = 56;
  // The receiver holds off for this long once, well past the depth of the chain.
  localparam int unsigned HOLD_CYCLES = 300;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // Share of cycles, in percent, in which a side idles while it is allowed to.
  localparam int unsigned IDLE_PCT    = 32;

  // Byte substitution table of the cipher.
  localparam logic [7:0] BELT_SUBST [256] = '{
    'hB1,'h94,'hBA,'hC8,'h0A,'h08,'hF5,'h3B,'h36,'h6D,'h00,'h8E,'h58,'h4A,'h5D,'hE4,
    'h85,'h04,'hFA,'h9D,'h1B,'hB6,'hC7,'hAC,'h25,'h2E,'h72,'hC2,'h02,'hFD,'hCE,'h0D,
    'h5B,'hE3,'hD6,'h12,'h17,'hB9,'h61,'h81,'hFE,'h67,'h86,'hAD,'h71,'h6B,'h89,'h0B,
    'h5C,'hB0,'hC0,'hFF,'h33,'hC3,'h56,'hB8,'h35,'hC4,'h05,'hAE,'hD8,'hE0,'h7F,'h99,
    'hE1,'h2B,'hDC,'h1A,'hE2,'h82,'h57,'hEC,'h70,'h3F,'hCC,'hF0,'h95,'hEE,'h8D,'hF1,
    'hC1,'hAB,'h76,'h38,'h9F,'hE6,'h78,'hCA,'hF7,'hC6,'hF8,'h60,'hD5,'hBB,'h9C,'h4F,
    'hF3,'h3C,'h65,'h7B,'h63,'h7C,'h30,'h6A,'hDD,'h4E,'hA7,'h79,'h9E,'hB2,'h3D,'h31,
    'h3E,'h98,'hB5,'h6E,'h27,'hD3,'hBC,'hCF,'h59,'h1E,'h18,'h1F,'h4C,'h5A,'hB7,'h93,
    'hE9,'hDE,'hE7,'h2C,'h8F,'h0C,'h0F,'hA6,'h2D,'hDB,'h49,'hF4,'h6F,'h73,'h96,'h47,
    'h06,'h07,'h53,'h16,'hED,'h24,'h7A,'h37,'h39,'hCB,'hA3,'h83,'h03,'hA9,'h8B,'hF6,
    'h92,'hBD,'h9B,'h1C,'hE5,'hD1,'h41,'h01,'h54,'h45,'hFB,'hC9,'h5E,'h4D,'h0E,'hF2,
    'h68,'h20,'h80,'hAA,'h22,'h7D,'h64,'h2F,'h26,'h87,'hF9,'h34,'h90,'h40,'h55,'h11,
    'hBE,'h32,'h97,'h13,'h43,'hFC,'h9A,'h48,'hA0,'h2A,'h88,'h5F,'h19,'h4B,'h09,'hA1,
    'h7E,'hCD,'hA4,'hD0,'h15,'h44,'hAF,'h8C,'hA5,'h84,'h50,'hBF,'h66,'hD2,'hE8,'h8A,
    'hA2,'hD7,'h46,'h52,'h42,'hA8,'hDF,'hB3,'h69,'h74,'hC5,'h51,'hEB,'h23,'h29,'h21,
    'hD4,'hEF,'hD9,'hB4,'h3A,'h62,'h28,'h75,'h91,'h14,'h10,'hEA,'h77,'h6C,'hDA,'h1D
  };

  // Tracks the key registers as the unit should hold them, works out the result block of
  // every accepted transaction and checks the results against them in order.
  class cipher_ledger;
    logic [63:0] key01, key23, key45, key67;
    logic [1:0]  key_size;
    belt_out_t   expected_blocks[$];
    int unsigned mismatches;

    function new();
      key01 = '0;
      key23 = '0;
      key45 = '0;
      key67 = '0;
      key_size = KEY_SIZE_256;
      mismatches = 0;
    endfunction

    // Indexes past the key-size register are ignored, as the unit ignores them.
    function void set_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        CFG_KEY_01:   key01 = data;
        CFG_KEY_23:   key23 = data;
        CFG_KEY_45:   key45 = data;
        CFG_KEY_67:   key67 = data;
        CFG_KEY_SIZE: key_size = data[1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0][31:0] expanded_key();
      logic [7:0][31:0] w;
      w = {key67, key45, key23, key01};
      case (key_size)
        KEY_SIZE_128: w[7:4] = w[3:0];
        KEY_SIZE_192: begin
          w[6] = w[0] ^ w[1] ^ w[2];
          w[7] = w[3] ^ w[4] ^ w[5];
        end
        // The 256-bit size and the unused code both take all eight words.
        default: ;
      endcase
      return w;
    endfunction

    // G transform: substitute every byte, then rotate left.
    function logic [31:0] g_mix(logic [31:0] x, int unsigned rot);
      logic [31:0] y;
      y = {BELT_SUBST[x[31:24]], BELT_SUBST[x[23:16]], BELT_SUBST[x[15:8]], BELT_SUBST[x[7:0]]};
      return (y << rot) | (y >> (32 - rot));
    endfunction

    function belt_out_t belt_crypt(belt_in_t blk);
      logic [7:0][31:0] w;
      logic [31:0] a, b, c, d, e, t;
      int unsigned r, base;
      belt_out_t res;
      w = expanded_key();
      a = blk.in_word0;
      b = blk.in_word1;
      c = blk.in_word2;
      d = blk.in_word3;
      for (int unsigned j = 0; j < 8; j++) begin
        if (blk.cmd == CMD_ENCRYPT) begin
          r = j;
          base = 7 * r;
          b ^= g_mix(a + w[base % 8], 5);
          c ^= g_mix(d + w[(base + 1) % 8], 21);
          a -= g_mix(b + w[(base + 2) % 8], 13);
          e = g_mix(b + c + w[(base + 3) % 8], 21) ^ 32'(r + 1);
          b += e;
          c -= e;
          d += g_mix(c + w[(base + 4) % 8], 13);
          b ^= g_mix(a + w[(base + 5) % 8], 21);
          c ^= g_mix(d + w[(base + 6) % 8], 5);
          t = a; a = b; b = t;
          t = c; c = d; d = t;
          t = b; b = c; c = t;
        end else begin
          // Decryption walks the rounds backwards with the key words mirrored.
          r = 7 - j;
          base = 7 * r;
          b ^= g_mix(a + w[(base + 6) % 8], 5);
          c ^= g_mix(d + w[(base + 5) % 8], 21);
          a -= g_mix(b + w[(base + 4) % 8], 13);
          e = g_mix(b + c + w[(base + 3) % 8], 21) ^ 32'(r + 1);
          b += e;
          c -= e;
          d += g_mix(c + w[(base + 2) % 8], 13);
          b ^= g_mix(a + w[(base + 1) % 8], 21);
          c ^= g_mix(d + w[base % 8], 5);
          t = a; a = b; b = t;
          t = c; c = d; d = t;
          t = a; a = d; d = t;
        end
      end
      if (blk.cmd == CMD_ENCRYPT) begin
        res.out_word0 = b;
        res.out_word1 = d;
        res.out_word2 = a;
        res.out_word3 = c;
      end else begin
        res.out_word0 = c;
        res.out_word1 = a;
        res.out_word2 = d;
        res.out_word3 = b;
      end
      return res;
    endfunction

    function void note_block(belt_in_t blk);
      expected_blocks.push_back(belt_crypt(blk));
    endfunction

    function void check_block(belt_out_t got);
      belt_out_t want;
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %h arrived with no transaction outstanding", $realtime, got);
        return;
      end
      want = expected_blocks.pop_front();
      if (got.out_word0 !== want.out_word0 || got.out_word1 !== want.out_word1 ||
          got.out_word2 !== want.out_word2 || got.out_word3 !== want.out_word3) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch, expected %h %h %h %h, got %h %h %h %h", $realtime,
                   want.out_word0, want.out_word1, want.out_word2, want.out_word3,
                   got.out_word0, got.out_word1, got.out_word2, got.out_word3);
      end
    endfunction

    function int unsigned pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = CFG_KEY_01;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  belt_in_t    in_data = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  belt_out_t   out_data;

  // Idling controls shared between the stimulus and the receiver.
  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;
  logic hold_req  = 1'b0;

  cipher_ledger ledger;

  belt_block_cipher_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One register write. The enable is raised and lowered in separate steps, so that
  // back-to-back writes never assign it twice in one time step.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_reg(idx, data);
  endtask

  // Loads a whole key; the key-size write carries random upper bits, which must be ignored.
  task automatic load_key(input logic [63:0] k01, input logic [63:0] k23,
                          input logic [63:0] k45, input logic [63:0] k67,
                          input logic [1:0] size);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    write_reg(CFG_KEY_01, k01);
    write_reg(CFG_KEY_23, k23);
    write_reg(CFG_KEY_45, k45);
    write_reg(CFG_KEY_67, k67);
    write_reg(CFG_KEY_SIZE, {junk[63:2], size});
  endtask

  // Offers one transaction, with random idle cycles ahead of it unless the sender is calm,
  // and returns in the step at which it was accepted.
  task automatic send_block(input belt_in_t blk);
    if (!send_calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    do @(posedge clk); while (in_stall);
    ledger.note_block(blk);
  endtask

  // Random blocks, with all-zero and all-one words mixed in now and then.
  task automatic send_random(input int unsigned count);
    belt_in_t blk;
    logic [31:0] words [4];
    repeat (count) begin
      foreach (words[k]) begin
        case ($urandom_range(15))
          0: words[k] = '0;
          1: words[k] = '1;
          default: words[k] = $urandom();
        endcase
      end
      blk.cmd      = $urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT;
      blk.in_word0 = words[0];
      blk.in_word1 = words[1];
      blk.in_word2 = words[2];
      blk.in_word3 = words[3];
      send_block(blk);
    end
  endtask

  // Every transaction yields a result, so an empty ledger means the chain is empty too.
  task automatic wait_drained(input int unsigned guard);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (guard) @(posedge clk);
  endtask

  // Every accepted result is checked against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_block(out_data);
  end

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (recv_calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Ends the run if no transaction on either channel is accepted for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] k [4];
    ledger = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key (all zero, full 256-bit size): zero, all-one, single-word and alternating-bit blocks.
    send_block({CMD_ENCRYPT, 128'h0});
    send_block({CMD_DECRYPT, 128'h0});
    send_block({CMD_ENCRYPT, {4{32'hFFFF_FFFF}}});
    send_block({CMD_DECRYPT, {4{32'hFFFF_FFFF}}});
    send_block({CMD_ENCRYPT, 32'hFFFF_FFFF, 96'h0});
    send_block({CMD_ENCRYPT, 32'h0, 32'hFFFF_FFFF, 64'h0});
    send_block({CMD_ENCRYPT, 64'h0, 32'hFFFF_FFFF, 32'h0});
    send_block({CMD_ENCRYPT, 96'h0, 32'hFFFF_FFFF});
    send_block({CMD_ENCRYPT, {2{64'hAAAA_AAAA_5555_5555}}});
    send_block({CMD_DECRYPT, {2{64'h5555_5555_AAAA_AAAA}}});
    wait_drained(2);

    // All-one key at 128 bits, where the upper four words repeat the lower four.
    load_key('1, '1, '1, '1, KEY_SIZE_128);
    send_block({CMD_ENCRYPT, 128'h0});
    send_block({CMD_DECRYPT, 128'h0});
    send_block({CMD_ENCRYPT, {4{32'hFFFF_FFFF}}});
    send_block({CMD_DECRYPT, {4{32'hFFFF_FFFF}}});
    send_random(150);
    wait_drained(2);

    // Random key at 192 bits, where words 6 and 7 are derived by XOR.
    foreach (k[i]) k[i] = {$urandom(), $urandom()};
    load_key(k[0], k[1], k[2], k[3], KEY_SIZE_192);
    send_random(150);
    wait_drained(2);

    // Random full-size key, with neither side idling at all.
    foreach (k[i]) k[i] = {$urandom(), $urandom()};
    load_key(k[0], k[1], k[2], k[3], KEY_SIZE_256);
    send_calm = 1'b1;
    recv_calm = 1'b1;
    send_random(150);
    wait_drained(2);
    recv_calm = 1'b0;

    // The unused key-size code acts as a full key. The receiver holds off for a long
    // stretch while the sender keeps offering, so the chain fills and stalls its input.
    foreach (k[i]) k[i] = {$urandom(), $urandom()};
    load_key(k[0], k[1], k[2], k[3], KEY_SIZE_256 + 2'd1);
    hold_req = 1'b1;
    send_random(150);
    wait_drained(2);
    send_calm = 1'b0;

    // Writes beyond the key-size register must leave the key untouched.
    foreach (k[i]) k[i] = {$urandom(), $urandom()};
    load_key(k[0], k[1], k[2], k[3], KEY_SIZE_128);
    for (int n = 1; n <= 3; n++) write_reg(CFG_KEY_SIZE + 3'(n), {$urandom(), $urandom()});
    send_random(100);
    wait_drained(2);

    // Random key at a random size.
    foreach (k[i]) k[i] = {$urandom(), $urandom()};
    load_key(k[0], k[1], k[2], k[3], 2'($urandom_range(3)));
    send_random(100);
    wait_drained(LATENCY + 8);

    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/belt_pkg.sv
src/belt_step_cell.sv
src/belt_out_skid.sv
src/belt_block_cipher_unit.sv
sim/tb_top.sv
